@@ rtl/hslrgb_pkg.sv @@
`default_nettype none
package hslrgb_pkg;

	// component width, unsigned Q0.B
	localparam int unsigned B = 16;

	localparam logic [B:0] ONE  = (B+1)'(1) << B;
	localparam logic [B-1:0] HALF = B'(1) << (B - 1);

	localparam int unsigned MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HSV = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HSL = 2'd2;

	localparam logic [2:0] SECT_0 = 3'd0;
	localparam logic [2:0] SECT_1 = 3'd1;
	localparam logic [2:0] SECT_2 = 3'd2;
	localparam logic [2:0] SECT_3 = 3'd3;
	localparam logic [2:0] SECT_4 = 3'd4;

	typedef logic [B-1:0] comp_t;
	typedef logic [MODE_W-1:0] mode_t;

	// per-stage load enables from the top-level flow control
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

	// chroma stage result handed to the hue spread stages
	typedef struct packed {
		comp_t      c;
		comp_t      frac;
		logic [2:0] sector;
		comp_t      px;
		comp_t      py;
		comp_t      pz;
		mode_t      mode;
	} chroma_t;

	function automatic logic is_conv(input mode_t m);
		return (m == MODE_HSV) || (m == MODE_HSL);
	endfunction

	// add offset, clamp at full scale
	function automatic comp_t add_sat(input comp_t a, input comp_t b);
		logic [B:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[B] ? {B{1'b1}} : s[B-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/hslrgb_chroma.sv @@
`default_nettype none
module hslrgb_chroma (
	input  wire                      clk,
	input  wire hslrgb_pkg::pipe_en_t en,
	input  wire hslrgb_pkg::mode_t    mode,
	input  wire hslrgb_pkg::comp_t    px,
	input  wire hslrgb_pkg::comp_t    py,
	input  wire hslrgb_pkg::comp_t    pz,
	output hslrgb_pkg::chroma_t       chroma
);

	localparam int unsigned B = hslrgb_pkg::B;

	logic [B+2:0] h6;
	logic [B:0]   inv_l;
	logic [B:0]   fac;

	logic [B:0]          fac_s1;
	hslrgb_pkg::comp_t   frac_s1, px_s1, py_s1, pz_s1;
	logic [2:0]          sector_s1;
	hslrgb_pkg::mode_t   mode_s1;

	logic [2*B:0]        prod;
	hslrgb_pkg::chroma_t chroma_s2;

	always_comb begin
		h6    = ({3'b000, px} << 2) + ({3'b000, px} << 1);
		inv_l = hslrgb_pkg::ONE - {1'b0, pz};
		if (mode == hslrgb_pkg::MODE_HSL) begin
			// 2L or 2(1-L), exact
			if (pz <= hslrgb_pkg::HALF) begin
				fac = {pz, 1'b0};
			end else begin
				fac = {inv_l[B-1:0], 1'b0};
			end
		end else begin
			fac = {1'b0, pz};
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			fac_s1    <= fac;
			frac_s1   <= h6[B-1:0];
			sector_s1 <= h6[B+2:B];
			px_s1     <= px;
			py_s1     <= py;
			pz_s1     <= pz;
			mode_s1   <= mode;
		end
	end

	// fac <= 2^B and py < 2^B, so the product stays below 2^(2B)
	assign prod = {{B{1'b0}}, fac_s1} * {{(B+1){1'b0}}, py_s1};

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			chroma_s2.c      <= prod[2*B-1:B];
			chroma_s2.frac   <= frac_s1;
			chroma_s2.sector <= sector_s1;
			chroma_s2.px     <= px_s1;
			chroma_s2.py     <= py_s1;
			chroma_s2.pz     <= pz_s1;
			chroma_s2.mode   <= mode_s1;
		end
	end

	assign chroma = chroma_s2;

endmodule
`default_nettype wire

@@ rtl/hslrgb_spread.sv @@
`default_nettype none
module hslrgb_spread (
	input  wire                       clk,
	input  wire hslrgb_pkg::pipe_en_t  en,
	input  wire hslrgb_pkg::chroma_t   chroma,
	output hslrgb_pkg::comp_t          red,
	output hslrgb_pkg::comp_t          green,
	output hslrgb_pkg::comp_t          blue
);

	localparam int unsigned B = hslrgb_pkg::B;

	logic [B:0]        weight;
	logic [2*B:0]      prod;
	hslrgb_pkg::comp_t m;

	hslrgb_pkg::comp_t x_s3, c_s3, m_s3, px_s3, py_s3, pz_s3;
	logic [2:0]        sector_s3;
	hslrgb_pkg::mode_t mode_s3;

	hslrgb_pkg::comp_t r_base, g_base, b_base;
	hslrgb_pkg::comp_t red_s4, green_s4, blue_s4;

	always_comb begin
		// odd sectors fall: C*(1-f), even sectors rise: C*f
		if (chroma.sector[0]) begin
			weight = hslrgb_pkg::ONE - {1'b0, chroma.frac};
		end else begin
			weight = {1'b0, chroma.frac};
		end
		prod = {{(B+1){1'b0}}, chroma.c} * {{B{1'b0}}, weight};
		if (chroma.mode == hslrgb_pkg::MODE_HSL) begin
			m = chroma.pz - (chroma.c >> 1);
		end else begin
			m = chroma.pz - chroma.c;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			x_s3      <= prod[2*B-1:B];
			c_s3      <= chroma.c;
			m_s3      <= m;
			sector_s3 <= chroma.sector;
			mode_s3   <= chroma.mode;
			px_s3     <= chroma.px;
			py_s3     <= chroma.py;
			pz_s3     <= chroma.pz;
		end
	end

	always_comb begin
		unique case (sector_s3)
			hslrgb_pkg::SECT_0: begin
				r_base = c_s3; g_base = x_s3; b_base = '0;
			end
			hslrgb_pkg::SECT_1: begin
				r_base = x_s3; g_base = c_s3; b_base = '0;
			end
			hslrgb_pkg::SECT_2: begin
				r_base = '0; g_base = c_s3; b_base = x_s3;
			end
			hslrgb_pkg::SECT_3: begin
				r_base = '0; g_base = x_s3; b_base = c_s3;
			end
			hslrgb_pkg::SECT_4: begin
				r_base = x_s3; g_base = '0; b_base = c_s3;
			end
			default: begin
				r_base = c_s3; g_base = '0; b_base = x_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			if (hslrgb_pkg::is_conv(mode_s3)) begin
				red_s4   <= hslrgb_pkg::add_sat(r_base, m_s3);
				green_s4 <= hslrgb_pkg::add_sat(g_base, m_s3);
				blue_s4  <= hslrgb_pkg::add_sat(b_base, m_s3);
			end else begin
				red_s4   <= px_s3;
				green_s4 <= py_s3;
				blue_s4  <= pz_s3;
			end
		end
	end

	assign red   = red_s4;
	assign green = green_s4;
	assign blue  = blue_s4;

endmodule
`default_nettype wire

@@ rtl/hsv_hsl_to_rgb_unit.sv @@
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tdata: comp_x, comp_y, comp_z
// m_*       out  m_tvalid / m_tready   m_tdata: red, green, blue
// cfg_*     in   cfg_valid / cfg_ready cfg_data: mode_select
//
// Four register stages: hue*6 and chroma factor, chroma multiply,
// secondary multiply and offset, channel add with clamp.
// One word per cycle while m_tready stays high; a word passes through the
// stage registers in order and m_tvalid rises once it reaches the last one.
// arst_n clears the stage valid bits and the mode (raw pass-through).
// A stall holds the full stages behind it; earlier words fill the gaps.
`default_nettype none
module hsv_hsl_to_rgb_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [3*hslrgb_pkg::B-1:0]           s_tdata,  // comp_x, comp_y, comp_z
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [3*hslrgb_pkg::B-1:0]           m_tdata,  // red, green, blue
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [hslrgb_pkg::MODE_W-1:0]        cfg_data
);

	localparam int unsigned B = hslrgb_pkg::B;

	hslrgb_pkg::mode_t    mode_q;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 rdy1, rdy2, rdy3, rdy4;
	hslrgb_pkg::pipe_en_t en;
	hslrgb_pkg::chroma_t  chroma;
	hslrgb_pkg::comp_t    red, green, blue;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hslrgb_pkg::MODE_RAW;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// a stage takes a word when it is empty or its word moves on
	assign rdy4 = !v_s4 || m_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.en_s1 = s_tvalid && rdy1;
	assign en.en_s2 = v_s1 && rdy2;
	assign en.en_s3 = v_s2 && rdy3;
	assign en.en_s4 = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign s_tready = rdy1;
	assign m_tvalid = v_s4;

	hslrgb_chroma u_chroma (
		.clk    (clk),
		.en     (en),
		.mode   (mode_q),
		.px     (s_tdata[B-1:0]),
		.py     (s_tdata[2*B-1:B]),
		.pz     (s_tdata[3*B-1:2*B]),
		.chroma (chroma)
	);

	hslrgb_spread u_spread (
		.clk    (clk),
		.en     (en),
		.chroma (chroma),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	assign m_tdata = {blue, green, red};

endmodule
`default_nettype wire

@@ rtl/hslrgb_checker.sv @@
`default_nettype none
module hslrgb_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire [3*hslrgb_pkg::B-1:0]     s_tdata,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [3*hslrgb_pkg::B-1:0]     m_tdata,
	input wire                           cfg_valid,
	input wire                           cfg_ready,
	input wire [hslrgb_pkg::MODE_W-1:0]  cfg_data
);

	logic unused_ok;
	assign unused_ok = ^{s_tdata, cfg_valid, cfg_data};

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");

	// empty output stage means nothing upstream can block
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

	// with no stall, an accepted word moves through every stage and reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4)
		&& $past(s_tvalid && s_tready, 4)
		&& $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3)
		|-> m_tvalid)
		else $error("accepted word did not reach output in four cycles");

endmodule

bind hsv_hsl_to_rgb_unit hslrgb_checker u_hslrgb_checker (.*);
`default_nettype wire
